// ----- design/nps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nine-point stencil package
// Shared widths, beat types, configuration bundle and register codes for the
// 3x3 stencil block.
// ----------------------------------------------------------------------------
package nps_pkg;

  // Sample and weight formats.
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 16;
  localparam int COEF_FRAC   = 12;
  localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
  localparam int SUM_BITS    = PROD_BITS + 4;

  // Stencil geometry.
  localparam int STENCIL_DIM = 3;
  localparam int NUM_TAPS    = STENCIL_DIM * STENCIL_DIM;
  localparam int MIN_DIM     = 3;

  // Grid limits and register widths.
  localparam int DEFAULT_MAX_WIDTH = 1024;
  localparam int MAX_HEIGHT        = 4096;
  localparam int WIDTH_REG_BITS    = 11;
  localparam int HEIGHT_REG_BITS   = 13;
  localparam int RESET_WIDTH       = 1024;
  localparam int RESET_HEIGHT      = 1024;
  localparam int ROW_BITS          = 12;
  localparam int COL_OUT_BITS      = 10;

  // APB port geometry: 64-bit registers at 8-byte strides.
  localparam int APB_ADDR_BITS = 6;
  localparam int APB_DATA_BITS = 64;
  localparam int REG_SHIFT     = 3;
  localparam int REG_IDX_BITS  = APB_ADDR_BITS - REG_SHIFT;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_COEF_LOW    = 3'd0,
    REG_COEF_HIGH   = 3'd1,
    REG_COEF_LAST   = 3'd2,
    REG_GRID_WIDTH  = 3'd3,
    REG_GRID_HEIGHT = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          frame_start;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] result_value;
    logic [ROW_BITS-1:0]           result_row;
    logic [COL_OUT_BITS-1:0]       result_col;
    logic                          saturated;
    logic                          last_point;
  } out_beat_t;

  typedef struct packed {
    logic [APB_DATA_BITS-1:0]    coef_low_four;
    logic [APB_DATA_BITS-1:0]    coef_high_four;
    logic signed [COEF_BITS-1:0] coef_last;
    logic [WIDTH_REG_BITS-1:0]   grid_width;
    logic [HEIGHT_REG_BITS-1:0]  grid_height;
  } cfg_t;

  // Position tags that travel with a point down the pipeline.
  typedef struct packed {
    logic [ROW_BITS-1:0]     row;
    logic [COL_OUT_BITS-1:0] col;
    logic                    last;
  } meta_t;

endpackage

// ----- design/nps_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stencil configuration registers
// APB-style register file holding the nine weights and the grid geometry.
// ----------------------------------------------------------------------------
module nps_cfg import nps_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel_i,
  input  logic                     penable_i,
  input  logic                     pwrite_i,
  input  logic [APB_ADDR_BITS-1:0] paddr_i,
  input  logic [APB_DATA_BITS-1:0] pwdata_i,
  output logic [APB_DATA_BITS-1:0] prdata_o,
  output cfg_t                     cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e reg_idx;

  assign wr_en   = psel_i & penable_i & pwrite_i;
  assign reg_idx = reg_idx_e'(paddr_i[APB_ADDR_BITS-1:REG_SHIFT]);

  // Register writes; addresses beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_low_four  <= '0;
      cfg_q.coef_high_four <= '0;
      cfg_q.coef_last      <= '0;
      cfg_q.grid_width     <= WIDTH_REG_BITS'(RESET_WIDTH);
      cfg_q.grid_height    <= HEIGHT_REG_BITS'(RESET_HEIGHT);
    end else if (wr_en) begin
      case (reg_idx)
        REG_COEF_LOW:    cfg_q.coef_low_four  <= pwdata_i;
        REG_COEF_HIGH:   cfg_q.coef_high_four <= pwdata_i;
        REG_COEF_LAST:   cfg_q.coef_last      <= pwdata_i[COEF_BITS-1:0];
        REG_GRID_WIDTH:  cfg_q.grid_width     <= pwdata_i[WIDTH_REG_BITS-1:0];
        REG_GRID_HEIGHT: cfg_q.grid_height    <= pwdata_i[HEIGHT_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register.
  always_comb begin
    case (reg_idx)
      REG_COEF_LOW:    prdata_o = cfg_q.coef_low_four;
      REG_COEF_HIGH:   prdata_o = cfg_q.coef_high_four;
      REG_COEF_LAST:   prdata_o = APB_DATA_BITS'(unsigned'(cfg_q.coef_last));
      REG_GRID_WIDTH:  prdata_o = APB_DATA_BITS'(cfg_q.grid_width);
      REG_GRID_HEIGHT: prdata_o = APB_DATA_BITS'(cfg_q.grid_height);
      default:         prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/nps_line_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stencil line store
// One memory holding the upper and middle rows side by side, with a
// registered read port and write-first bypass on an address collision.
// ----------------------------------------------------------------------------
module nps_line_store import nps_pkg::*; #(
  parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rd_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr_i,
  output logic [2*SAMPLE_BITS-1:0]     rd_data_o,
  input  logic                         wr_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr_i,
  input  logic [2*SAMPLE_BITS-1:0]     wr_data_i
);

  logic [2*SAMPLE_BITS-1:0] mem_q [MAX_WIDTH];
  logic [2*SAMPLE_BITS-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port; a write to the same entry in the same cycle is passed through.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- design/nps_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stencil window cell
// Holds one window sample, hands it to its left neighbor on each shift and
// registers the sample times its weight.
// ----------------------------------------------------------------------------
module nps_cell import nps_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          shift_i,
  input  logic                          en_i,
  input  logic signed [SAMPLE_BITS-1:0] data_i,
  input  logic signed [COEF_BITS-1:0]   weight_i,
  output logic signed [SAMPLE_BITS-1:0] data_o,
  output logic signed [PROD_BITS-1:0]   prod_o
);

  logic signed [SAMPLE_BITS-1:0] tap_q;
  logic signed [PROD_BITS-1:0]   prod_d, prod_q;

  // Window tap, moves one column per accepted sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= '0;
    end else if (shift_i) begin
      tap_q <= data_i;
    end
  end

  // Weighted tap, registered before the adder tree.
  assign prod_d = PROD_BITS'(tap_q) * PROD_BITS'(weight_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign data_o = tap_q;
  assign prod_o = prod_q;

endmodule

// ----- design/nps_sum.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stencil sum
// Two-stage adder tree over the nine weighted taps, followed by rounding
// to the sample format and saturation.
// ----------------------------------------------------------------------------
module nps_sum import nps_pkg::*; (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [PROD_BITS-1:0]   prod_i [NUM_TAPS],
  output logic signed [SAMPLE_BITS-1:0] value_o,
  output logic                          sat_o
);

  localparam int RowBits = PROD_BITS + 2;
  localparam logic signed [SUM_BITS-1:0] RoundC = SUM_BITS'(2 ** (COEF_FRAC - 1));
  localparam logic signed [SUM_BITS-1:0] SatHi  =
    SUM_BITS'({1'b0, {(SAMPLE_BITS - 1){1'b1}}});
  localparam logic signed [SUM_BITS-1:0] SatLo  = ~SatHi;

  logic signed [RowBits-1:0]     row_sum_d [STENCIL_DIM];
  logic signed [RowBits-1:0]     row_sum_q [STENCIL_DIM];
  logic signed [SUM_BITS-1:0]    total, shifted;
  logic signed [SAMPLE_BITS-1:0] value_d, value_q;
  logic                          sat_d, sat_q;

  // First stage: one sum per window row.
  always_comb begin
    for (int i = 0; i < STENCIL_DIM; i++) begin
      row_sum_d[i] = RowBits'(prod_i[STENCIL_DIM*i])
                   + RowBits'(prod_i[STENCIL_DIM*i + 1])
                   + RowBits'(prod_i[STENCIL_DIM*i + 2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      row_sum_q <= row_sum_d;
    end
  end

  // Second stage: total, round half up, then clip to the sample range.
  always_comb begin
    total   = SUM_BITS'(row_sum_q[0]) + SUM_BITS'(row_sum_q[1])
            + SUM_BITS'(row_sum_q[2]) + RoundC;
    shifted = total >>> COEF_FRAC;
    if (shifted > SatHi) begin
      value_d = SatHi[SAMPLE_BITS-1:0];
      sat_d   = 1'b1;
    end else if (shifted < SatLo) begin
      value_d = SatLo[SAMPLE_BITS-1:0];
      sat_d   = 1'b1;
    end else begin
      value_d = shifted[SAMPLE_BITS-1:0];
      sat_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      value_q <= value_d;
      sat_q   <= sat_d;
    end
  end

  assign value_o = value_q;
  assign sat_o   = sat_q;

endmodule

// ----- design/nine_point_stencil_2d_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nine-point 3x3 stencil, top level
// Streams raster-ordered grid samples through two line stores and a row of
// nine window cells, and emits the rounded, saturated stencil sum for every
// interior point.
//
//   Channel  Direction  Handshake               Beat
//   in       sink       in_valid_i / in_stall_o   in_beat_t (sample, frame_start)
//   out      source     out_valid_o / out_stall_i out_beat_t (value, row, col, flags)
//   cfg      sink       APB psel/penable/pwrite   64-bit registers at 8-byte steps
//
// One sample beat is taken every cycle while in_stall_o is low; each result passes
// through the line store read, cell shift, products, row sums and final sum.
// After reset the line stores are cleared, one entry a cycle, across all MAX_WIDTH
// entries; in_stall_o stays high during that pass.
// Results go to a two-entry output queue; apart from that pass, in_stall_o rises
// only when the second entry fills, and the whole pipeline holds while it is full.
// ----------------------------------------------------------------------------
module nine_point_stencil_2d_top import nps_pkg::*; #(
  parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  in_beat_t                 in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output out_beat_t                out_data_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int LW        = (CW + 1 > ROW_BITS) ? CW + 1 : ROW_BITS;
  localparam int HW        = HEIGHT_REG_BITS;
  localparam int PipeDepth = 4;

  cfg_t                        cfg;
  logic signed [COEF_BITS-1:0] weight [NUM_TAPS];

  // Configuration registers.
  nps_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  assign pready = 1'b1;

  // Unpack the nine weights.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      weight[k]     = cfg.coef_low_four[COEF_BITS*k +: COEF_BITS];
      weight[k + 4] = cfg.coef_high_four[COEF_BITS*k +: COEF_BITS];
    end
    weight[NUM_TAPS-1] = cfg.coef_last;
  end

  // Effective grid size, clamped to the supported range.
  logic [LW-1:0] width_ext, width_eff;
  logic [HW-1:0] height_eff;

  always_comb begin
    width_ext = LW'(cfg.grid_width);
    if (width_ext < LW'(MIN_DIM)) begin
      width_eff = LW'(MIN_DIM);
    end else if (width_ext > LW'(MAX_WIDTH)) begin
      width_eff = LW'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
    if (cfg.grid_height < HW'(MIN_DIM)) begin
      height_eff = HW'(MIN_DIM);
    end else if (cfg.grid_height > HW'(MAX_HEIGHT)) begin
      height_eff = HW'(MAX_HEIGHT);
    end else begin
      height_eff = cfg.grid_height;
    end
  end

  // Flow control.
  logic en, accept, push, out_taken;
  logic clr_active_q, skid_full_q, out_valid_q;
  logic [CW-1:0] clr_addr_q;

  assign en         = ~skid_full_q;
  assign in_stall_o = clr_active_q | skid_full_q;
  assign accept     = in_valid_i & ~in_stall_o;

  // Raster position of the incoming sample.
  logic [CW-1:0]       col_q, col_cur, col_d;
  logic [ROW_BITS-1:0] row_q, row_cur, row_d;
  logic [LW-1:0]       col_ext, col_inc;
  logic [HW-1:0]       row_ext, row_inc;
  logic                emit, last;
  meta_t               meta0;

  always_comb begin
    col_cur = in_data_i.frame_start ? '0 : col_q;
    row_cur = in_data_i.frame_start ? '0 : row_q;
    col_ext = LW'(col_cur);
    row_ext = HW'(row_cur);
    col_inc = col_ext + LW'(1);
    row_inc = row_ext + HW'(1);
    emit    = (row_cur >= ROW_BITS'(2)) && (col_ext >= LW'(2))
           && (row_ext < height_eff) && (col_ext < width_eff);
    last    = (row_inc == height_eff) && (col_inc == width_eff);
    if (col_inc >= width_eff) begin
      col_d = '0;
      row_d = (row_inc >= height_eff) ? '0 : row_inc[ROW_BITS-1:0];
    end else begin
      col_d = col_inc[CW-1:0];
      row_d = row_cur;
    end
    meta0.row  = row_cur - ROW_BITS'(1);
    meta0.col  = col_inc[COL_OUT_BITS-1:0] - COL_OUT_BITS'(2);
    meta0.last = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Clearing pass over the line stores after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else if (clr_active_q) begin
      if (clr_addr_q == CW'(MAX_WIDTH - 1)) begin
        clr_active_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + CW'(1);
      end
    end
  end

  // Stage 1: sample waits for its line store read.
  logic                          v1_q, e1_q;
  meta_t                         meta1_q;
  logic signed [SAMPLE_BITS-1:0] sample1_q;
  logic [CW-1:0]                 addr1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_q      <= emit;
      meta1_q   <= meta0;
      sample1_q <= in_data_i.sample;
      addr1_q   <= col_cur;
    end
  end

  // Line stores: upper row in the high half, middle row in the low half.
  logic [2*SAMPLE_BITS-1:0]      rd_data, wr_data;
  logic [CW-1:0]                 wr_addr;
  logic                          wr_en;
  logic signed [SAMPLE_BITS-1:0] up_val, mid_val;

  assign up_val  = rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign mid_val = rd_data[SAMPLE_BITS-1:0];
  assign wr_en   = clr_active_q | (en & v1_q);
  assign wr_addr = clr_active_q ? clr_addr_q : addr1_q;
  assign wr_data = clr_active_q ? '0 : {mid_val, sample1_q};

  nps_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (en),
    .rd_addr_i (col_cur),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // Window: three rows of three cells, new column enters on the right.
  logic signed [SAMPLE_BITS-1:0] row_new [STENCIL_DIM];
  logic signed [SAMPLE_BITS-1:0] tap     [STENCIL_DIM][STENCIL_DIM];
  logic signed [SAMPLE_BITS-1:0] cell_in [STENCIL_DIM][STENCIL_DIM];
  logic signed [PROD_BITS-1:0]   prod    [NUM_TAPS];
  logic                          shift;

  assign row_new[0] = up_val;
  assign row_new[1] = mid_val;
  assign row_new[2] = sample1_q;
  assign shift      = en & v1_q;

  for (genvar gr = 0; gr < STENCIL_DIM; gr++) begin : g_row
    for (genvar gc = 0; gc < STENCIL_DIM; gc++) begin : g_col
      if (gc == STENCIL_DIM - 1) begin : g_edge
        assign cell_in[gr][gc] = row_new[gr];
      end else begin : g_chain
        assign cell_in[gr][gc] = tap[gr][gc+1];
      end
      nps_cell u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .shift_i  (shift),
        .en_i     (en),
        .data_i   (cell_in[gr][gc]),
        .weight_i (weight[STENCIL_DIM*gr + gc]),
        .data_o   (tap[gr][gc]),
        .prod_o   (prod[STENCIL_DIM*gr + gc])
      );
    end
  end

  // Adder tree, rounding and saturation.
  logic signed [SAMPLE_BITS-1:0] sum_value;
  logic                          sum_sat;

  nps_sum u_sum (
    .clk_i   (clk_i),
    .en_i    (en),
    .prod_i  (prod),
    .value_o (sum_value),
    .sat_o   (sum_sat)
  );

  // Valid and position tags alongside cells, products, row sums, final sum.
  logic [PipeDepth-1:0] pipe_vld_q;
  meta_t                pipe_meta_q [PipeDepth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_vld_q <= '0;
    end else if (en) begin
      pipe_vld_q <= {pipe_vld_q[PipeDepth-2:0], v1_q & e1_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pipe_meta_q[0] <= meta1_q;
      for (int i = 1; i < PipeDepth; i++) begin
        pipe_meta_q[i] <= pipe_meta_q[i-1];
      end
    end
  end

  // Output queue: output register plus one skid entry.
  out_beat_t final_beat, out_q, skid_q;

  assign final_beat.result_value = sum_value;
  assign final_beat.result_row   = pipe_meta_q[PipeDepth-1].row;
  assign final_beat.result_col   = pipe_meta_q[PipeDepth-1].col;
  assign final_beat.saturated    = sum_sat;
  assign final_beat.last_point   = pipe_meta_q[PipeDepth-1].last;

  assign push      = en & pipe_vld_q[PipeDepth-1];
  assign out_taken = out_valid_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else if (skid_full_q) begin
      if (out_taken) begin
        skid_full_q <= 1'b0;
      end
    end else if (!out_valid_q || out_taken) begin
      out_valid_q <= push;
    end else if (push) begin
      skid_full_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_full_q) begin
      if (out_taken) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || out_taken) begin
      if (push) begin
        out_q <= final_beat;
      end
    end else if (push) begin
      skid_q <= final_beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  // A queued skid beat always sits behind a valid output beat.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_full_q |-> out_valid_q)
    else $error("skid entry full while output register empty");

  // Nothing moves through the pipeline while the line stores are cleared.
  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> (!v1_q && (pipe_vld_q == '0)))
    else $error("pipeline busy during line store clearing");

  // A full skid entry is only released by the sink taking a beat.
  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_full_q && out_stall_i) |=> skid_full_q)
    else $error("skid entry dropped without an output beat");
`endif

endmodule
